// ----- src/cnlv_pkg.sv -----
`timescale 1ns / 1ps

package cnlv_pkg;

    // Character codes of interest in the number stream.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Operation codes.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Card type codes.
    localparam logic [2:0] TYPE_MASTER    = 3'd0;
    localparam logic [2:0] TYPE_VISA      = 3'd1;
    localparam logic [2:0] TYPE_AMEX      = 3'd2;
    localparam logic [2:0] TYPE_DISCOVER  = 3'd3;
    localparam logic [2:0] TYPE_CORPORATE = 3'd4;

    // Length and expiry limits.
    localparam int unsigned LEN_LONG       = 16;
    localparam int unsigned LEN_VISA_SHORT = 13;
    localparam int unsigned LEN_AMEX       = 15;
    localparam logic [6:0]  MONTH_MAX      = 7'd12;
    localparam logic [6:0]  YEAR_FLOOR     = 7'd90;

    // Result reason codes.
    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_NO_NAME  = 3'd1,
        REASON_MONTH    = 3'd2,
        REASON_YEAR     = 3'd3,
        REASON_BAD_CHAR = 3'd4,
        REASON_SHAPE    = 3'd5,
        REASON_CHECKSUM = 3'd6
    } reason_t;

    // Accumulated number state, apart from the digit count.
    typedef struct packed {
        logic [3:0][3:0] lead;
        logic [1:0][3:0] plain;
        logic [1:0][3:0] dbl;
        logic            bad;
    } acc_state_t;

    // Sum of two decimal digits, reduced mod 10.
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 5'd10)
            begin
                s = s - 5'd10;
            end
            add_mod10 = s[3:0];
        end
    endfunction

    // Digit sum of a doubled decimal digit.
    function automatic logic [3:0] double_digit(input logic [3:0] d);
        logic [4:0] t;
        begin
            t = {d, 1'b0};
            if (t >= 5'd10)
            begin
                t = t - 5'd9;
            end
            double_digit = t[3:0];
        end
    endfunction

endpackage

// ----- src/cnlv_accum.sv -----
`timescale 1ns / 1ps

module cnlv_accum #(
    parameter int MAX_DIGITS = 31,
    parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic                    clear,
    input  logic [7:0]              char_code,
    output cnlv_pkg::acc_state_t    acc,
    output logic [CNT_W-1:0]        count
);

    import cnlv_pkg::*;

    acc_state_t       acc_reg;
    acc_state_t       acc_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [3:0]       digit;
    logic             par;
    logic             is_digit;
    logic             is_skip;
    logic             saturated;

    assign digit     = 4'(char_code - CHAR_ZERO);
    assign par       = count_reg[0];
    assign is_skip   = (char_code == CHAR_SPACE) || (char_code == CHAR_DASH);
    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign saturated = (count_reg >= CNT_W'(MAX_DIGITS));

    // Fold one character into the accumulators, or clear after an end request.
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        if (clear)
        begin
            acc_next   = '0;
            count_next = '0;
        end
        else if (take && !is_skip && !saturated)
        begin
            if (!is_digit)
            begin
                acc_next.bad = 1'b1;
            end
            else
            begin
                if (count_reg < CNT_W'(4))
                begin
                    acc_next.lead[count_reg[1:0]] = digit;
                end
                acc_next.plain[par] = add_mod10(acc_reg.plain[par], digit);
                acc_next.dbl[par]   = add_mod10(acc_reg.dbl[par], double_digit(digit));
                count_next          = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    assign acc   = acc_reg;
    assign count = count_reg;

endmodule

// ----- src/cnlv_check.sv -----
`timescale 1ns / 1ps

module cnlv_check #(
    parameter int MAX_DIGITS = 31,
    parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
    input  cnlv_pkg::acc_state_t    acc,
    input  logic [CNT_W-1:0]        count,
    input  logic [2:0]              card_type,
    input  logic                    name_present,
    input  logic [6:0]              expiry_month,
    input  logic [6:0]              expiry_year,
    output cnlv_pkg::reason_t       reason
);

    import cnlv_pkg::*;

    logic len_long;
    logic shape_ok;
    logic luhn_ok;

    assign len_long = (count == CNT_W'(LEN_LONG));

    // Length and prefix rules by card type.
    always_comb
    begin
        case (card_type)
            TYPE_MASTER:
                shape_ok = len_long && (acc.lead[0] == 4'd5) &&
                           (acc.lead[1] inside {[4'd1:4'd5]});
            TYPE_VISA:
                shape_ok = (len_long || (count == CNT_W'(LEN_VISA_SHORT))) &&
                           (acc.lead[0] == 4'd4);
            TYPE_AMEX:
                shape_ok = (count == CNT_W'(LEN_AMEX)) && (acc.lead[0] == 4'd3) &&
                           (acc.lead[1] inside {4'd4, 4'd7});
            TYPE_DISCOVER:
                shape_ok = len_long && (acc.lead[0] == 4'd6) && (acc.lead[1] == 4'd0) &&
                           (acc.lead[2] == 4'd1) && (acc.lead[3] == 4'd1);
            TYPE_CORPORATE:
                shape_ok = len_long && (acc.lead[0] == 4'd9);
            default:
                shape_ok = 1'b0;
        endcase
    end

    // The rightmost digit takes its plain value; the other parity is doubled.
    assign luhn_ok = (add_mod10(acc.plain[~count[0]], acc.dbl[count[0]]) == 4'd0);

    // The first failing check sets the reason.
    always_comb
    begin
        reason = REASON_OK;
        if ((card_type != TYPE_CORPORATE) && !name_present)
        begin
            reason = REASON_NO_NAME;
        end
        else if ((card_type != TYPE_CORPORATE) &&
                 ((expiry_month < 7'd1) || (expiry_month > MONTH_MAX)))
        begin
            reason = REASON_MONTH;
        end
        else if ((card_type != TYPE_CORPORATE) && (expiry_year <= YEAR_FLOOR))
        begin
            reason = REASON_YEAR;
        end
        else if (acc.bad)
        begin
            reason = REASON_BAD_CHAR;
        end
        else if (!shape_ok)
        begin
            reason = REASON_SHAPE;
        end
        else if (!luhn_ok)
        begin
            reason = REASON_CHECKSUM;
        end
    end

endmodule

// ----- src/card_number_luhn_validator_unit.sv -----
`timescale 1ns / 1ps

// Card number checker with the mod 10 (Luhn) rule.
// The request channel (item_valid / item_ready) carries one card number
// character per request with op at 0; spaces and dashes are skipped and any
// other non-digit marks the number bad. A request with op at 1 ends the number
// and carries card type, name presence and expiry month and year.
// The result channel (res_valid / res_ready) returns valid_res and a reason
// code for each end request only; character requests give no result.
// A request may be accepted every cycle, except while an end request waits in
// the input register. A request lands in an input register, and an end
// request's result is loaded from there into the result register once it is free.
// When the receiver stalls, character requests keep flowing; an end request
// waits in the input register until the result register is free, which then
// holds item_ready low.
// Reset clears the digit count, the leading digits, all checksum sums and the
// bad character flag, and empties both registers.

module card_number_luhn_validator_unit #(
    parameter int MAX_DIGITS = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       op,
    input  logic [7:0] char_code,
    input  logic [2:0] card_type,
    input  logic       name_present,
    input  logic [6:0] expiry_month,
    input  logic [6:0] expiry_year,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       valid_res,
    output logic [2:0] reason
);

    import cnlv_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_op_reg;
    logic [7:0]       s1_char_reg;
    logic [2:0]       s1_type_reg;
    logic             s1_name_reg;
    logic [6:0]       s1_month_reg;
    logic [6:0]       s1_year_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    reason_t          reason_reg;
    reason_t          check_reason;
    acc_state_t       acc;
    logic [CNT_W-1:0] count;
    logic             out_free;
    logic             s1_go;
    logic             item_fire;

    // Handshake control.
    assign out_free   = !res_valid_reg || res_ready;
    assign s1_go      = s1_valid_reg && ((s1_op_reg == OP_CHAR) || out_free);
    assign item_ready = !s1_valid_reg || s1_go;
    assign item_fire  = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_go && (s1_op_reg == OP_END))
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_op_reg    <= op;
            s1_char_reg  <= char_code;
            s1_type_reg  <= card_type;
            s1_name_reg  <= name_present;
            s1_month_reg <= expiry_month;
            s1_year_reg  <= expiry_year;
        end
    end

    // Number state accumulators.
    cnlv_accum #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (s1_go && (s1_op_reg == OP_CHAR)),
        .clear     (s1_go && (s1_op_reg == OP_END)),
        .char_code (s1_char_reg),
        .acc       (acc),
        .count     (count)
    );

    // Final record checks.
    cnlv_check #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W)
    ) u_check (
        .acc          (acc),
        .count        (count),
        .card_type    (s1_type_reg),
        .name_present (s1_name_reg),
        .expiry_month (s1_month_reg),
        .expiry_year  (s1_year_reg),
        .reason       (check_reason)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_op_reg == OP_END))
        begin
            reason_reg <= check_reason;
        end
    end

    assign res_valid = res_valid_reg;
    assign reason    = reason_reg;
    assign valid_res = (reason_reg == REASON_OK);

endmodule

// ----- bench/tb_card_number_luhn_validator_unit.sv -----
`timescale 1ns / 1ps

module tb_card_number_luhn_validator_unit;

    import cnlv_pkg::*;

    localparam int MAX_DIGITS = 31;
    localparam int CLK_PERIOD = 12;
    localparam int RANDOM_ITEMS = 600;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam logic [2:0] TYPE_LAST = 3'd7;
    localparam logic [7:0] CHAR_LETTER_A = 8'h41;

    // Expected outcome of one end request.
    typedef struct {
        logic    valid_res;
        reason_t reason;
    } card_verdict_t;

    // Clock, reset and block inputs, all known from time zero.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       op = OP_CHAR;
    logic [7:0] char_code = 8'd0;
    logic [2:0] card_type = 3'd0;
    logic       name_present = 1'b0;
    logic [6:0] expiry_month = 7'd0;
    logic [6:0] expiry_year = 7'd0;
    logic       res_ready = 1'b0;

    // Block outputs.
    logic       item_ready;
    logic       res_valid;
    logic       valid_res;
    logic [2:0] reason;

    // Mirror of the number state inside the block.
    int unsigned digits_taken;
    logic [3:0]  lead_q [4];
    logic [3:0]  plain_acc [2];
    logic [3:0]  dbl_acc [2];
    logic        bad_seen;

    // Verdicts still owed by the block, oldest first.
    card_verdict_t verdict_q[$];

    // Card numbers under construction.
    logic [3:0] digit_buf[$];
    logic [7:0] char_buf[$];

    int unsigned items_sent = 0;
    int          fail_count = 0;
    bit          tx_gaps_on = 1'b0;
    bit          rx_stalls_on = 1'b0;
    int          stall_left = 0;

    card_number_luhn_validator_unit #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .op(op),
        .char_code(char_code),
        .card_type(card_type),
        .name_present(name_present),
        .expiry_month(expiry_month),
        .expiry_year(expiry_year),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .valid_res(valid_res),
        .reason(reason)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_number();
        digits_taken = 0;
        for (int i = 0; i < 4; i++)
        begin
            lead_q[i] = 4'd0;
        end
        for (int i = 0; i < 2; i++)
        begin
            plain_acc[i] = 4'd0;
            dbl_acc[i] = 4'd0;
        end
        bad_seen = 1'b0;
    endfunction

    // Fold one number character into the mirrored sums.
    function automatic void absorb_char(input logic [7:0] c);
        int unsigned digit;
        int unsigned par;
        int unsigned twice;
        int unsigned tmp;
        if (c == CHAR_SPACE || c == CHAR_DASH)
        begin
            return;
        end
        if (digits_taken >= MAX_DIGITS)
        begin
            return;
        end
        if (c < CHAR_ZERO || c > CHAR_NINE)
        begin
            bad_seen = 1'b1;
            return;
        end
        digit = c - CHAR_ZERO;
        par = digits_taken % 2;
        if (digits_taken < 4)
        begin
            lead_q[digits_taken] = digit[3:0];
        end
        tmp = plain_acc[par] + digit;
        plain_acc[par] = tmp % 10;
        twice = 2 * digit;
        if (twice >= 10)
        begin
            twice = twice - 9;
        end
        tmp = dbl_acc[par] + twice;
        dbl_acc[par] = tmp % 10;
        digits_taken++;
    endfunction

    // Length and leading digits allowed for each card type.
    function automatic bit shape_matches(input logic [2:0] ty);
        case (ty)
            TYPE_MASTER:
                return digits_taken == LEN_LONG && lead_q[0] == 5 &&
                       lead_q[1] >= 1 && lead_q[1] <= 5;
            TYPE_VISA:
                return (digits_taken == LEN_LONG || digits_taken == LEN_VISA_SHORT) &&
                       lead_q[0] == 4;
            TYPE_AMEX:
                return digits_taken == LEN_AMEX && lead_q[0] == 3 &&
                       (lead_q[1] == 4 || lead_q[1] == 7);
            TYPE_DISCOVER:
                return digits_taken == LEN_LONG && lead_q[0] == 6 && lead_q[1] == 0 &&
                       lead_q[2] == 1 && lead_q[3] == 1;
            TYPE_CORPORATE:
                return digits_taken == LEN_LONG && lead_q[0] == 9;
            default:
                return 1'b0;
        endcase
    endfunction

    // Verdict for an end request; the number state starts over afterwards.
    function automatic card_verdict_t judge_card(input logic [2:0] ty, input logic nm,
                                                 input logic [6:0] mo, input logic [6:0] yr);
        card_verdict_t v;
        reason_t       why;
        int unsigned   sum;
        why = REASON_OK;
        if (ty != TYPE_CORPORATE)
        begin
            if (!nm)
            begin
                why = REASON_NO_NAME;
            end
            else if (mo < 1 || mo > MONTH_MAX)
            begin
                why = REASON_MONTH;
            end
            else if (yr <= YEAR_FLOOR)
            begin
                why = REASON_YEAR;
            end
        end
        if (why == REASON_OK)
        begin
            // The rightmost digit stays plain, its neighbors are doubled.
            sum = plain_acc[(digits_taken + 1) % 2] + dbl_acc[digits_taken % 2];
            if (bad_seen)
            begin
                why = REASON_BAD_CHAR;
            end
            else if (!shape_matches(ty))
            begin
                why = REASON_SHAPE;
            end
            else if (sum % 10 != 0)
            begin
                why = REASON_CHECKSUM;
            end
        end
        v.valid_res = (why == REASON_OK);
        v.reason = why;
        clear_number();
        return v;
    endfunction

    // Present one request, hold it until taken, then update the mirror.
    task automatic send_request(input logic op_i, input logic [7:0] ch_i,
                                input logic [2:0] ty_i, input logic nm_i,
                                input logic [6:0] mo_i, input logic [6:0] yr_i);
        int   gap;
        logic hit;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op <= op_i;
        char_code <= ch_i;
        card_type <= ty_i;
        name_present <= nm_i;
        expiry_month <= mo_i;
        expiry_year <= yr_i;
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = item_ready;
            @(posedge clk);
        end
        items_sent++;
        if (op_i == OP_CHAR)
        begin
            absorb_char(ch_i);
        end
        else
        begin
            verdict_q.push_back(judge_card(ty_i, nm_i, mo_i, yr_i));
        end
    endtask

    // Stop sending and let every owed verdict come back.
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Digits for a type's prefix, padded at random, closed by a Luhn check digit.
    task automatic build_number(input logic [2:0] ty, input int len);
        int unsigned sum;
        int unsigned dv;
        digit_buf.delete();
        case (ty)
            TYPE_MASTER:
            begin
                digit_buf.push_back(4'd5);
                digit_buf.push_back(4'($urandom_range(1, 5)));
            end
            TYPE_VISA:
                digit_buf.push_back(4'd4);
            TYPE_AMEX:
            begin
                digit_buf.push_back(4'd3);
                digit_buf.push_back($urandom_range(0, 1) ? 4'd7 : 4'd4);
            end
            TYPE_DISCOVER:
            begin
                digit_buf.push_back(4'd6);
                digit_buf.push_back(4'd0);
                digit_buf.push_back(4'd1);
                digit_buf.push_back(4'd1);
            end
            TYPE_CORPORATE:
                digit_buf.push_back(4'd9);
            default:
                digit_buf.push_back(4'($urandom_range(0, 9)));
        endcase
        while (digit_buf.size() > len)
        begin
            void'(digit_buf.pop_back());
        end
        while (digit_buf.size() < len - 1)
        begin
            digit_buf.push_back(4'($urandom_range(0, 9)));
        end
        if (digit_buf.size() < len)
        begin
            sum = 0;
            for (int i = 0; i < digit_buf.size(); i++)
            begin
                dv = digit_buf[i];
                if ((len - 1 - i) % 2 == 1)
                begin
                    dv = 2 * dv;
                    if (dv > 9)
                    begin
                        dv = dv - 9;
                    end
                end
                sum += dv;
            end
            digit_buf.push_back(4'((10 - sum % 10) % 10));
        end
    endtask

    // Turn the digits into characters, with spaces and dashes sprinkled in.
    task automatic emit_number(input int sep_pct);
        char_buf.delete();
        foreach (digit_buf[i])
        begin
            if ($urandom_range(0, 99) < sep_pct)
            begin
                char_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_DASH);
            end
            char_buf.push_back(CHAR_ZERO + 8'(digit_buf[i]));
        end
    endtask

    // One whole card record; unused fields carry random values.
    task automatic send_record(input logic [2:0] ty, input logic nm,
                               input logic [6:0] mo, input logic [6:0] yr);
        foreach (char_buf[i])
        begin
            send_request(OP_CHAR, char_buf[i], 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                         7'($urandom_range(0, 127)));
        end
        send_request(OP_END, 8'($urandom_range(0, 255)), ty, nm, mo, yr);
    endtask

    task automatic directed_card(input logic [2:0] ty, input int len, input int sep_pct,
                                 input logic nm, input logic [6:0] mo, input logic [6:0] yr);
        build_number(ty, len);
        emit_number(sep_pct);
        send_record(ty, nm, mo, yr);
    endtask

    // A correct number of every type, back to back with no idling.
    task automatic test_well_formed_cards();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        directed_card(TYPE_MASTER, LEN_LONG, 0, 1'b1, MONTH_MAX, 7'd99);
        directed_card(TYPE_VISA, LEN_LONG, 0, 1'b1, 7'd1, 7'd91);
        directed_card(TYPE_VISA, LEN_VISA_SHORT, 30, 1'b1, 7'd6, 7'd95);
        directed_card(TYPE_AMEX, LEN_AMEX, 30, 1'b1, 7'd7, 7'd99);
        directed_card(TYPE_DISCOVER, LEN_LONG, 0, 1'b1, 7'd11, 7'd92);
        directed_card(TYPE_CORPORATE, LEN_LONG, 0, 1'b1, 7'd3, 7'd93);
    endtask

    // Name and expiry checks, and the corporate type that skips them.
    task automatic test_expiry_and_name();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        directed_card(TYPE_MASTER, LEN_LONG, 0, 1'b0, 7'd5, 7'd95);
        directed_card(TYPE_MASTER, LEN_LONG, 0, 1'b1, 7'd0, 7'd95);
        directed_card(TYPE_MASTER, LEN_LONG, 0, 1'b1, MONTH_MAX + 7'd1, 7'd95);
        directed_card(TYPE_MASTER, LEN_LONG, 0, 1'b1, 7'd99, 7'd95);
        directed_card(TYPE_VISA, LEN_LONG, 0, 1'b1, 7'd5, YEAR_FLOOR);
        directed_card(TYPE_VISA, LEN_LONG, 0, 1'b1, 7'd5, 7'd0);
        directed_card(TYPE_AMEX, LEN_AMEX, 0, 1'b1, 7'd1, YEAR_FLOOR + 7'd1);
        directed_card(TYPE_CORPORATE, LEN_LONG, 0, 1'b0, 7'd0, 7'd0);
    endtask

    // Bad characters, shape failures, checksum, empty and saturated numbers.
    task automatic test_character_cases();
        logic [2:0] ty;
        // A letter inside an otherwise good number.
        build_number(TYPE_MASTER, LEN_LONG);
        emit_number(0);
        char_buf.insert(5, CHAR_LETTER_A);
        send_record(TYPE_MASTER, 1'b1, 7'd4, 7'd96);
        // Extreme character codes; a missing name still takes priority.
        build_number(TYPE_VISA, LEN_LONG);
        emit_number(0);
        char_buf.push_back(8'hFF);
        char_buf.push_front(8'h00);
        send_record(TYPE_VISA, 1'b1, 7'd4, 7'd96);
        build_number(TYPE_VISA, LEN_LONG);
        emit_number(0);
        char_buf.push_back(8'h7F);
        send_record(TYPE_VISA, 1'b0, 7'd4, 7'd96);
        // Last digit off by one breaks the checksum.
        build_number(TYPE_DISCOVER, LEN_LONG);
        digit_buf[LEN_LONG - 1] = 4'((digit_buf[LEN_LONG - 1] + 1) % 10);
        emit_number(0);
        send_record(TYPE_DISCOVER, 1'b1, 7'd8, 7'd97);
        // Empty number.
        char_buf.delete();
        send_record(TYPE_VISA, 1'b1, 7'd8, 7'd97);
        // Unknown card types.
        for (ty = TYPE_CORPORATE + 3'd1; ty != 3'd0; ty++)
        begin
            directed_card(ty, LEN_LONG, 0, 1'b1, 7'd2, 7'd98);
            if (ty == TYPE_LAST)
            begin
                break;
            end
        end
        // Too many digits, then a letter that the saturated count ignores.
        build_number(TYPE_CORPORATE, 40);
        emit_number(10);
        char_buf.push_back(CHAR_LETTER_A);
        send_record(TYPE_CORPORATE, 1'b1, 7'd2, 7'd98);
        // Wrong prefix and wrong length.
        build_number(TYPE_DISCOVER, LEN_LONG);
        emit_number(0);
        send_record(TYPE_MASTER, 1'b1, 7'd9, 7'd99);
        directed_card(TYPE_VISA, LEN_VISA_SHORT + 1, 0, 1'b1, 7'd9, 7'd99);
    endtask

    // One random record: mostly well formed with at most a single flaw, some pure noise.
    task automatic random_record();
        int         flavor;
        int         len;
        int         pos;
        int         tmp;
        logic [2:0] ty;
        logic       nm;
        logic [6:0] mo;
        logic [6:0] yr;
        if ($urandom_range(0, 99) < 80)
        begin
            ty = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
            case (ty)
                TYPE_VISA:
                    len = $urandom_range(0, 1) ? LEN_VISA_SHORT : LEN_LONG;
                TYPE_AMEX:
                    len = LEN_AMEX;
                default:
                    len = LEN_LONG;
            endcase
            flavor = $urandom_range(0, 11);
            if (flavor == 0)
            begin
                len = $urandom_range(0, 1) ? len + 1 : len - 1;
            end
            build_number(ty, len);
            if (flavor == 1)
            begin
                pos = $urandom_range(0, digit_buf.size() - 1);
                tmp = digit_buf[pos] + $urandom_range(1, 9);
                digit_buf[pos] = 4'(tmp % 10);
            end
            emit_number($urandom_range(0, 1) ? 0 : 25);
            if (flavor == 2)
            begin
                pos = $urandom_range(0, char_buf.size());
                char_buf.insert(pos, 8'($urandom_range(0, 255)));
            end
            nm = 1'b1;
            mo = 7'($urandom_range(1, 12));
            yr = 7'($urandom_range(91, 99));
            if (flavor == 3)
            begin
                nm = 1'b0;
            end
            if (flavor == 4)
            begin
                mo = 7'($urandom_range(0, 99));
            end
            if (flavor == 5)
            begin
                yr = 7'($urandom_range(0, 99));
            end
        end
        else
        begin
            char_buf.delete();
            len = $urandom_range(0, 40);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    char_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                else
                begin
                    char_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            ty = 3'($urandom_range(0, 7));
            nm = 1'($urandom_range(0, 1));
            mo = 7'($urandom_range(0, 99));
            yr = 7'($urandom_range(0, 99));
        end
        send_record(ty, nm, mo, yr);
    endtask

    // Random records with idling switched on and off in stretches.
    task automatic test_random_records();
        int unsigned start;
        bit          paused;
        start = items_sent;
        paused = 1'b0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_gaps_on = !tx_gaps_on;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                rx_stalls_on = !rx_stalls_on;
            end
            random_record();
            // Once midway, hold off until the block has answered everything.
            if (!paused && items_sent - start > RANDOM_ITEMS / 2)
            begin
                wait_drain();
                paused = 1'b1;
            end
        end
    endtask

    // Result side readiness with random stalls.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
            if (rx_stalls_on)
            begin
                stall_left <= pick_gap();
            end
        end
    end

    // Compare each accepted result with the oldest owed verdict.
    always @(negedge clk)
    begin
        card_verdict_t want;
        if (rst_n && res_valid === 1'b1 && res_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with none expected, valid_res=%0b reason=%0d",
                         $time, valid_res, reason);
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (valid_res !== want.valid_res)
                begin
                    $display("%0t: valid_res mismatch, expected %0b, got %0b",
                             $time, want.valid_res, valid_res);
                    fail_count++;
                end
                if (reason !== want.reason)
                begin
                    $display("%0t: reason mismatch, expected %0d, got %0d",
                             $time, want.reason, reason);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        clear_number();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_well_formed_cards();
        wait_drain();
        test_expiry_and_name();
        wait_drain();
        test_character_cases();
        wait_drain();
        test_random_records();
        wait_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

endmodule
